/* hw/rtl/imc_pkg.sv */
package imc_pkg;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
   } req_type;

   typedef struct packed {
      logic signed [23:0] roll_angle;
      logic signed [23:0] pitch_angle;
      logic signed [23:0] yaw_angle;
   } rsp_type;

   // CORDIC working set: vector and accumulated angle in Q16 degrees.
   typedef struct packed {
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic signed [27:0] z;
   } crd_type;

   localparam logic [1:0] REG_BLEND_ALPHA   = 2'd0;
   localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd1;
   localparam logic [1:0] REG_GYRO_SCALE    = 2'd2;

   localparam logic [15:0] BLEND_ALPHA_RST   = 16'd32113;
   localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd328;
   localparam logic [15:0] GYRO_SCALE_RST    = 16'd3996;
   localparam logic [15:0] ALPHA_ONE         = 16'd32768;

   localparam int CAL_SAMPLES_DEF  = 50;
   localparam int CORDIC_ITERS_DEF = 16;

   // 180 degrees in Q16.
   localparam logic signed [27:0] HALF_TURN = 28'sd11796480;

   function automatic logic signed [27:0] atan_q16(input logic [4:0] idx);
      logic signed [27:0] v;
      case (idx)
         5'd0:  v = 28'sd2949120;
         5'd1:  v = 28'sd1740967;
         5'd2:  v = 28'sd919879;
         5'd3:  v = 28'sd466945;
         5'd4:  v = 28'sd234379;
         5'd5:  v = 28'sd117266;
         5'd6:  v = 28'sd58666;
         5'd7:  v = 28'sd29335;
         5'd8:  v = 28'sd14668;
         5'd9:  v = 28'sd7334;
         5'd10: v = 28'sd3667;
         5'd11: v = 28'sd1833;
         5'd12: v = 28'sd917;
         5'd13: v = 28'sd458;
         5'd14: v = 28'sd229;
         5'd15: v = 28'sd115;
         5'd16: v = 28'sd57;
         5'd17: v = 28'sd29;
         5'd18: v = 28'sd14;
         5'd19: v = 28'sd7;
         5'd20: v = 28'sd4;
         5'd21: v = 28'sd2;
         5'd22: v = 28'sd1;
         default: v = 28'sd0;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      return v[15] ? 16'(-v) : 16'(v);
   endfunction

   // Folds the left half plane onto the right one before vectoring.
   function automatic crd_type crd_pre(input logic signed [27:0] x,
                                       input logic signed [27:0] y);
      crd_type c;
      if (x < 0) begin
         c.x = -x;
         c.y = -y;
         c.z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
         c.x = x;
         c.y = y;
         c.z = '0;
      end
      return c;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [51:0] v);
      if (v > 52'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -52'sd8388608) begin
         return 24'sh800000;
      end else begin
         return v[23:0];
      end
   endfunction

endpackage

/* hw/rtl/imu_complementary_attitude.sv */
// A filtered request runs through twelve bit-serial multiplies, a 25-step square root
// and two CORDIC passes of CORDIC_ITERS iterations. Calibration requests use only the
// first two multiplies and give no result; the last one adds four serial divisions.
// No new request is taken until the block is back in idle, but one is taken while the
// previous result waits on the rsp side.
// Synchronous active-high reset clears calibration and filter state and returns the registers to their reset values.
module imu_complementary_attitude #(
   parameter int CAL_SAMPLES  = imc_pkg::CAL_SAMPLES_DEF,
   parameter int CORDIC_ITERS = imc_pkg::CORDIC_ITERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  imc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output imc_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [4:0] S_IDLE = 5'd0, S_SQ_AZ = 5'd1, S_SQRT_INIT = 5'd2,
      S_SQRT = 5'd3, S_CRD_ROLL = 5'd4, S_CORDIC = 5'd5, S_ROLL_END = 5'd6,
      S_PITCH_END = 5'd7, S_CAL = 5'd8, S_CAL_CHK = 5'd9, S_DV1 = 5'd10,
      S_DV2 = 5'd11, S_DV3 = 5'd12, S_DV4 = 5'd13, S_RUN = 5'd14, S_G1 = 5'd15,
      S_G2 = 5'd16, S_G3 = 5'd17, S_G4 = 5'd18, S_G5 = 5'd19, S_B1 = 5'd20,
      S_B2 = 5'd21, S_B3 = 5'd22, S_B4 = 5'd23, S_B5 = 5'd24, S_OUT = 5'd25,
      S_MUL = 5'd26, S_DIV = 5'd27;

   localparam logic [7:0] CAL_N     = 8'(CAL_SAMPLES);
   localparam logic [4:0] CRD_LAST  = 5'(CORDIC_ITERS - 1);
   localparam logic [4:0] MUL_LAST  = 5'd15;
   localparam logic [4:0] SQRT_LAST = 5'd24;
   localparam logic [4:0] DIV_LAST  = 5'd31;

   logic [4:0] state_ff, state_in, ret_ff, ret_in, cnt_ff, cnt_in;
   imc_pkg::req_type req_ff, req_in;
   imc_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] alpha_reg_ff, alpha_reg_in, period_ff, period_in, scale_ff, scale_in;

   logic signed [51:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [15:0] mplr_ff, mplr_in;
   logic [49:0] sq_n_ff, sq_n_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   imc_pkg::crd_type crd_ff, crd_in;
   logic [31:0] dq_ff, dq_in;
   logic [7:0] drem_ff, drem_in;
   logic dneg_ff, dneg_in;

   logic signed [16:0] roll_acc_ff, roll_acc_in, pitch_acc_ff, pitch_acc_in;
   logic [7:0] calib_count_ff, calib_count_in;
   logic calib_done_ff, calib_done_in;
   logic signed [23:0] sum_rate_x_ff, sum_rate_x_in, sum_rate_y_ff, sum_rate_y_in;
   logic signed [31:0] sum_roll_ff, sum_roll_in, sum_pitch_ff, sum_pitch_in;
   logic signed [15:0] bias_x_ff, bias_x_in, bias_y_ff, bias_y_in;
   logic signed [16:0] roll_zero_ff, roll_zero_in, pitch_zero_ff, pitch_zero_in;
   logic signed [23:0] roll_state_ff, roll_state_in, pitch_state_ff, pitch_state_in;
   logic signed [23:0] yaw_state_ff, yaw_state_in;
   logic signed [28:0] g_roll_ff, g_roll_in, g_pitch_ff, g_pitch_in, g_yaw_ff, g_yaw_in;

   logic [15:0] alpha, beta;
   logic signed [51:0] rnd24, rnd15, rnd8;
   logic [49:0] sq_try;
   logic signed [27:0] sh_x, sh_y, crd_round;
   logic [8:0] drem_sh;
   logic signed [31:0] quot;
   logic wr_en;

   assign alpha = (alpha_reg_ff > imc_pkg::ALPHA_ONE) ? imc_pkg::ALPHA_ONE : alpha_reg_ff;
   assign beta  = imc_pkg::ALPHA_ONE - alpha;
   assign rnd24 = (acc_ff + 52'sd8388608) >>> 24;
   assign rnd15 = (acc_ff + 52'sd16384) >>> 15;
   assign rnd8  = (acc_ff + 52'sd128) >>> 8;
   assign sq_try = sq_res_ff + sq_bit_ff;
   assign sh_x = crd_ff.x >>> cnt_ff;
   assign sh_y = crd_ff.y >>> cnt_ff;
   assign crd_round = (crd_ff.z + 28'sd128) >>> 8;
   assign drem_sh = {drem_ff, dq_ff[31]};
   assign quot = dneg_ff ? -$signed(dq_ff) : $signed(dq_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         imc_pkg::REG_BLEND_ALPHA:   prdata = {16'd0, alpha_reg_ff};
         imc_pkg::REG_SAMPLE_PERIOD: prdata = {16'd0, period_ff};
         imc_pkg::REG_GYRO_SCALE:    prdata = {16'd0, scale_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; cnt_in = cnt_ff;
      req_in = req_ff; rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      alpha_reg_in = alpha_reg_ff; period_in = period_ff; scale_in = scale_ff;
      acc_in = acc_ff; mcand_in = mcand_ff; mplr_in = mplr_ff;
      sq_n_in = sq_n_ff; sq_res_in = sq_res_ff; sq_bit_in = sq_bit_ff;
      crd_in = crd_ff; dq_in = dq_ff; drem_in = drem_ff; dneg_in = dneg_ff;
      roll_acc_in = roll_acc_ff; pitch_acc_in = pitch_acc_ff;
      calib_count_in = calib_count_ff; calib_done_in = calib_done_ff;
      sum_rate_x_in = sum_rate_x_ff; sum_rate_y_in = sum_rate_y_ff;
      sum_roll_in = sum_roll_ff; sum_pitch_in = sum_pitch_ff;
      bias_x_in = bias_x_ff; bias_y_in = bias_y_ff;
      roll_zero_in = roll_zero_ff; pitch_zero_in = pitch_zero_ff;
      roll_state_in = roll_state_ff; pitch_state_in = pitch_state_ff;
      yaw_state_in = yaw_state_ff;
      g_roll_in = g_roll_ff; g_pitch_in = g_pitch_ff; g_yaw_in = g_yaw_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (wr_en) begin
         case (paddr[3:2])
            imc_pkg::REG_BLEND_ALPHA:   alpha_reg_in = pwdata[15:0];
            imc_pkg::REG_SAMPLE_PERIOD: period_in = pwdata[15:0];
            imc_pkg::REG_GYRO_SCALE:    scale_in = pwdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               mcand_in = 52'(imc_pkg::mag16(req_data.accel_y));
               mplr_in = imc_pkg::mag16(req_data.accel_y);
               acc_in = '0; cnt_in = '0; ret_in = S_SQ_AZ; state_in = S_MUL;
            end
         end
         S_SQ_AZ: begin
            mcand_in = 52'(imc_pkg::mag16(req_ff.accel_z));
            mplr_in = imc_pkg::mag16(req_ff.accel_z);
            cnt_in = '0; ret_in = S_SQRT_INIT; state_in = S_MUL;
         end
         S_SQRT_INIT: begin
            sq_n_in = {acc_ff[33:0], 16'd0};
            sq_res_in = '0;
            sq_bit_in = 50'd1 << 48;
            cnt_in = '0; state_in = S_SQRT;
         end
         S_SQRT: begin
            // One result bit per step of the digit-by-digit root.
            if (sq_n_ff >= sq_try) begin
               sq_n_in = sq_n_ff - sq_try;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = S_CRD_ROLL;
            end
         end
         S_CRD_ROLL: begin
            crd_in = imc_pkg::crd_pre({{4{req_ff.accel_z[15]}}, req_ff.accel_z, 8'd0},
                                      {{4{req_ff.accel_y[15]}}, req_ff.accel_y, 8'd0});
            cnt_in = '0; ret_in = S_ROLL_END; state_in = S_CORDIC;
         end
         S_CORDIC: begin
            // Once y reaches zero the vector stays put.
            if (crd_ff.y > 0) begin
               crd_in.x = crd_ff.x + sh_y;
               crd_in.y = crd_ff.y - sh_x;
               crd_in.z = crd_ff.z + imc_pkg::atan_q16(cnt_ff);
            end else if (crd_ff.y < 0) begin
               crd_in.x = crd_ff.x - sh_y;
               crd_in.y = crd_ff.y + sh_x;
               crd_in.z = crd_ff.z - imc_pkg::atan_q16(cnt_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == CRD_LAST) begin
               state_in = ret_ff;
            end
         end
         S_ROLL_END: begin
            roll_acc_in = crd_round[16:0];
            crd_in = imc_pkg::crd_pre($signed({3'd0, sq_res_ff[24:0]}),
                                      -$signed({{4{req_ff.accel_x[15]}}, req_ff.accel_x, 8'd0}));
            cnt_in = '0; ret_in = S_PITCH_END; state_in = S_CORDIC;
         end
         S_PITCH_END: begin
            pitch_acc_in = crd_round[16:0];
            state_in = calib_done_ff ? S_RUN : S_CAL;
         end
         S_CAL: begin
            sum_rate_x_in = sum_rate_x_ff + 24'(req_ff.rate_x);
            sum_rate_y_in = sum_rate_y_ff + 24'(req_ff.rate_y);
            sum_roll_in = sum_roll_ff + 32'(roll_acc_ff);
            sum_pitch_in = sum_pitch_ff + 32'(pitch_acc_ff);
            calib_count_in = calib_count_ff + 8'd1;
            state_in = S_CAL_CHK;
         end
         S_CAL_CHK: begin
            if (calib_count_ff >= CAL_N) begin
               dq_in = sum_rate_x_ff[23] ? 32'(-sum_rate_x_ff) : 32'(sum_rate_x_ff);
               dneg_in = sum_rate_x_ff[23];
               drem_in = '0; cnt_in = '0; ret_in = S_DV1; state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DV1: begin
            bias_x_in = quot[15:0];
            dq_in = sum_rate_y_ff[23] ? 32'(-sum_rate_y_ff) : 32'(sum_rate_y_ff);
            dneg_in = sum_rate_y_ff[23];
            drem_in = '0; cnt_in = '0; ret_in = S_DV2; state_in = S_DIV;
         end
         S_DV2: begin
            bias_y_in = quot[15:0];
            dq_in = sum_roll_ff[31] ? 32'(-sum_roll_ff) : 32'(sum_roll_ff);
            dneg_in = sum_roll_ff[31];
            drem_in = '0; cnt_in = '0; ret_in = S_DV3; state_in = S_DIV;
         end
         S_DV3: begin
            roll_zero_in = quot[16:0];
            dq_in = sum_pitch_ff[31] ? 32'(-sum_pitch_ff) : 32'(sum_pitch_ff);
            dneg_in = sum_pitch_ff[31];
            drem_in = '0; cnt_in = '0; ret_in = S_DV4; state_in = S_DIV;
         end
         S_DV4: begin
            pitch_zero_in = quot[16:0];
            roll_state_in = '0;
            pitch_state_in = '0;
            calib_done_in = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (drem_sh >= {1'b0, CAL_N}) begin
               drem_in = 8'(drem_sh - {1'b0, CAL_N});
               dq_in = {dq_ff[30:0], 1'b1};
            end else begin
               drem_in = drem_sh[7:0];
               dq_in = {dq_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ret_ff;
            end
         end
         S_RUN: begin
            mcand_in = 52'(17'(req_ff.rate_x) - 17'(bias_x_ff));
            mplr_in = scale_ff;
            acc_in = '0; cnt_in = '0; ret_in = S_G1; state_in = S_MUL;
         end
         S_G1: begin
            mcand_in = acc_ff; mplr_in = period_ff;
            acc_in = '0; cnt_in = '0; ret_in = S_G2; state_in = S_MUL;
         end
         S_G2: begin
            g_roll_in = 29'(roll_state_ff) + rnd24[28:0];
            mcand_in = 52'(17'(req_ff.rate_y) - 17'(bias_y_ff));
            mplr_in = scale_ff;
            acc_in = '0; cnt_in = '0; ret_in = S_G3; state_in = S_MUL;
         end
         S_G3: begin
            mcand_in = acc_ff; mplr_in = period_ff;
            acc_in = '0; cnt_in = '0; ret_in = S_G4; state_in = S_MUL;
         end
         S_G4: begin
            g_pitch_in = 29'(pitch_state_ff) + rnd24[28:0];
            mcand_in = 52'(req_ff.rate_z); mplr_in = period_ff;
            acc_in = '0; cnt_in = '0; ret_in = S_G5; state_in = S_MUL;
         end
         S_G5: begin
            g_yaw_in = 29'(yaw_state_ff) + rnd8[28:0];
            mcand_in = 52'(g_roll_ff); mplr_in = alpha;
            acc_in = '0; cnt_in = '0; ret_in = S_B1; state_in = S_MUL;
         end
         S_B1: begin
            // The accelerometer term accumulates onto the gyro term.
            mcand_in = 52'(18'(roll_acc_ff) - 18'(roll_zero_ff));
            mplr_in = beta;
            cnt_in = '0; ret_in = S_B2; state_in = S_MUL;
         end
         S_B2: begin
            roll_state_in = imc_pkg::sat24(rnd15);
            mcand_in = 52'(g_pitch_ff); mplr_in = alpha;
            acc_in = '0; cnt_in = '0; ret_in = S_B3; state_in = S_MUL;
         end
         S_B3: begin
            mcand_in = 52'(18'(pitch_acc_ff) - 18'(pitch_zero_ff));
            mplr_in = beta;
            cnt_in = '0; ret_in = S_B4; state_in = S_MUL;
         end
         S_B4: begin
            pitch_state_in = imc_pkg::sat24(rnd15);
            mcand_in = 52'(g_yaw_ff); mplr_in = alpha;
            acc_in = '0; cnt_in = '0; ret_in = S_B5; state_in = S_MUL;
         end
         S_B5: begin
            yaw_state_in = imc_pkg::sat24(rnd15);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.roll_angle = roll_state_ff;
               rsp_in.pitch_angle = pitch_state_ff;
               rsp_in.yaw_angle = yaw_state_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            // Shift-and-add multiply, one multiplier bit per cycle.
            if (mplr_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = mcand_ff <<< 1;
            mplr_in = mplr_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         alpha_reg_ff <= imc_pkg::BLEND_ALPHA_RST;
         period_ff <= imc_pkg::SAMPLE_PERIOD_RST;
         scale_ff <= imc_pkg::GYRO_SCALE_RST;
         calib_count_ff <= '0;
         calib_done_ff <= 1'b0;
         sum_rate_x_ff <= '0;
         sum_rate_y_ff <= '0;
         sum_roll_ff <= '0;
         sum_pitch_ff <= '0;
         bias_x_ff <= '0;
         bias_y_ff <= '0;
         roll_zero_ff <= '0;
         pitch_zero_ff <= '0;
         roll_state_ff <= '0;
         pitch_state_ff <= '0;
         yaw_state_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         alpha_reg_ff <= alpha_reg_in;
         period_ff <= period_in;
         scale_ff <= scale_in;
         calib_count_ff <= calib_count_in;
         calib_done_ff <= calib_done_in;
         sum_rate_x_ff <= sum_rate_x_in;
         sum_rate_y_ff <= sum_rate_y_in;
         sum_roll_ff <= sum_roll_in;
         sum_pitch_ff <= sum_pitch_in;
         bias_x_ff <= bias_x_in;
         bias_y_ff <= bias_y_in;
         roll_zero_ff <= roll_zero_in;
         pitch_zero_ff <= pitch_zero_in;
         roll_state_ff <= roll_state_in;
         pitch_state_ff <= pitch_state_in;
         yaw_state_ff <= yaw_state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff <= mplr_in;
      sq_n_ff <= sq_n_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      crd_ff <= crd_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      dneg_ff <= dneg_in;
      roll_acc_ff <= roll_acc_in;
      pitch_acc_ff <= pitch_acc_in;
      g_roll_ff <= g_roll_in;
      g_pitch_ff <= g_pitch_in;
      g_yaw_ff <= g_yaw_in;
   end

endmodule

/* bench/imu_complementary_attitude_test.sv */
`timescale 1ns / 100ps

module imu_complementary_attitude_test;

   localparam int  CAL_COUNT  = 50;
   localparam int  ATAN_STEPS = 16;
   localparam int  SETTLE     = 800;
   localparam longint CYCLE_LIMIT = 8000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   imc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   imc_pkg::rsp_type rsp_data;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [3:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;

   imu_complementary_attitude dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // Arctangent of 2^-i in Q16 degrees.
   localparam longint ATAN_DEG [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   // Predictor copy of the registers and the filter state.
   logic [15:0]        alpha_reg = imc_pkg::BLEND_ALPHA_RST;
   logic [15:0]        period_reg = imc_pkg::SAMPLE_PERIOD_RST;
   logic [15:0]        scale_reg = imc_pkg::GYRO_SCALE_RST;
   int                 cal_seen = 0;
   bit                 cal_done = 1'b0;
   longint             acc_rate_x = 0, acc_rate_y = 0, acc_roll = 0, acc_pitch = 0;
   logic signed [15:0] offset_x = '0, offset_y = '0;
   logic signed [16:0] level_roll = '0, level_pitch = '0;
   logic signed [23:0] roll_q = '0, pitch_q = '0, yaw_q = '0;

   imc_pkg::req_type pending_reqs[$];
   imc_pkg::rsp_type expected_angles[$];
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      rsp_idle_pct = 0;
   int      rsp_hold_cycles = 0;
   longint  cycle_count = 0;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) begin
         return 8388607;
      end else if (v < -8388608) begin
         return -8388608;
      end
      return v;
   endfunction

   function automatic longint exact_root(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = longint'(1) << 48;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(root);
   endfunction

   // Vectoring-mode arctangent, result in 1/256 degree.
   function automatic longint vector_angle(longint y, longint x);
      longint z = 0;
      longint nx, ny;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 11796480 : -11796480;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < ATAN_STEPS; i++) begin
         if (y == 0) break;
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_DEG[i];
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_DEG[i];
         end
         x = nx;
         y = ny;
      end
      return round_shift(z, 8);
   endfunction

   function automatic void predict_attitude(imc_pkg::req_type r);
      longint ax = r.accel_x, ay = r.accel_y, az = r.accel_z;
      longint gx = r.rate_x, gy = r.rate_y, gz = r.rate_z;
      longint alpha = (alpha_reg > imc_pkg::ALPHA_ONE) ? 32768 : longint'(alpha_reg);
      longint beta = 32768 - alpha;
      longint per = period_reg, scl = scale_reg;
      longint mag, roll_acc, pitch_acc, roll_g, pitch_g, yaw_g;
      imc_pkg::rsp_type e;
      mag = exact_root(longint'(ay * ay + az * az) << 16);
      roll_acc = vector_angle(ay * 256, az * 256);
      pitch_acc = vector_angle(-ax * 256, mag);
      if (!cal_done) begin
         acc_rate_x += gx;
         acc_rate_y += gy;
         acc_roll += roll_acc;
         acc_pitch += pitch_acc;
         cal_seen++;
         if (cal_seen >= CAL_COUNT) begin
            offset_x = 16'(acc_rate_x / CAL_COUNT);
            offset_y = 16'(acc_rate_y / CAL_COUNT);
            level_roll = 17'(acc_roll / CAL_COUNT);
            level_pitch = 17'(acc_pitch / CAL_COUNT);
            roll_q = '0;
            pitch_q = '0;
            cal_done = 1'b1;
         end
         return;
      end
      roll_g = roll_q + round_shift((gx - offset_x) * scl * per, 24);
      pitch_g = pitch_q + round_shift((gy - offset_y) * scl * per, 24);
      roll_acc -= level_roll;
      pitch_acc -= level_pitch;
      roll_q = 24'(clamp24(round_shift(alpha * roll_g + beta * roll_acc, 15)));
      pitch_q = 24'(clamp24(round_shift(alpha * pitch_g + beta * pitch_acc, 15)));
      yaw_g = yaw_q + round_shift(gz * per, 8);
      yaw_q = 24'(clamp24(round_shift(alpha * yaw_g, 15)));
      e.roll_angle = roll_q;
      e.pitch_angle = pitch_q;
      e.yaw_angle = yaw_q;
      expected_angles.push_back(e);
   endfunction

   function automatic logic signed [15:0] near(int center, int spread);
      return 16'(center + $signed($urandom_range(2 * spread)) - spread);
   endfunction

   // Mostly a sensor near rest in some orientation, sometimes anything at all.
   function automatic imc_pkg::req_type random_sample();
      imc_pkg::req_type r;
      int g;
      if ($urandom_range(99) < 25) begin
         r = {$urandom, $urandom, $urandom};
      end else begin
         g = $urandom_range(1) ? 16384 : -16384;
         r.accel_x = near(($urandom_range(2) == 0) ? g : 0, 4000);
         r.accel_y = near(($urandom_range(2) == 1) ? g : 0, 4000);
         r.accel_z = near(($urandom_range(2) == 2) ? g : 0, 4000);
         r.rate_x = near(0, 2000);
         r.rate_y = near(0, 2000);
         r.rate_z = near(0, 2000);
      end
      return r;
   endfunction

   function automatic imc_pkg::req_type make_sample(int ax, int ay, int az,
                                                    int gx, int gy, int gz);
      imc_pkg::req_type r;
      r.accel_x = 16'(ax); r.accel_y = 16'(ay); r.accel_z = 16'(az);
      r.rate_x = 16'(gx); r.rate_y = 16'(gy); r.rate_z = 16'(gz);
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("imu_complementary_attitude test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_attitude(req_data);
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      imc_pkg::rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_angles.size() == 0) begin
               $error("unexpected result roll %0d pitch %0d yaw %0d",
                      rsp_data.roll_angle, rsp_data.pitch_angle, rsp_data.yaw_angle);
               fail_count++;
            end else begin
               e = expected_angles.pop_front();
               if (rsp_data.roll_angle !== e.roll_angle) begin
                  $error("roll_angle expected %0d actual %0d",
                         e.roll_angle, rsp_data.roll_angle);
                  fail_count++;
               end
               if (rsp_data.pitch_angle !== e.pitch_angle) begin
                  $error("pitch_angle expected %0d actual %0d",
                         e.pitch_angle, rsp_data.pitch_angle);
                  fail_count++;
               end
               if (rsp_data.yaw_angle !== e.yaw_angle) begin
                  $error("yaw_angle expected %0d actual %0d",
                         e.yaw_angle, rsp_data.yaw_angle);
                  fail_count++;
               end
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles <= rsp_hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic write_register(logic [1:0] index, logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {index, 2'b00}; pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (index)
         imc_pkg::REG_BLEND_ALPHA:   alpha_reg = value;
         imc_pkg::REG_SAMPLE_PERIOD: period_reg = value;
         imc_pkg::REG_GYRO_SCALE:    scale_reg = value;
         default: ;
      endcase
   endtask

   task automatic configure(logic [15:0] alpha, logic [15:0] per, logic [15:0] scl);
      write_register(imc_pkg::REG_BLEND_ALPHA, alpha);
      write_register(imc_pkg::REG_SAMPLE_PERIOD, per);
      write_register(imc_pkg::REG_GYRO_SCALE, scl);
   endtask

   // Calibration samples leave nothing to wait for, so a settling time follows.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_angles.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      repeat (count) pending_reqs.push_back(random_sample());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      configure(imc_pkg::BLEND_ALPHA_RST, imc_pkg::SAMPLE_PERIOD_RST,
                imc_pkg::GYRO_SCALE_RST);

      queue_random(CAL_COUNT);
      pending_reqs.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
      pending_reqs.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      pending_reqs.push_back(make_sample(0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_sample(16384, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_sample(0, 0, 16384, 100, -100, 50));
      pending_reqs.push_back(make_sample(0, 0, -16384, -100, 100, -50));
      pending_reqs.push_back(make_sample(0, 16384, 0, 0, 0, 0));
      pending_reqs.push_back(make_sample(0, -16384, 0, 0, 0, 0));
      pending_reqs.push_back(make_sample(-32768, 0, 0, 32767, -32768, 0));
      pending_reqs.push_back(make_sample(32767, -32768, 32767, -32768, 32767, 32767));
      pending_reqs.push_back(make_sample(-32768, 32767, -32768, 0, 0, -32768));
      pending_reqs.push_back(make_sample(1, -1, 1, -1, 1, -1));
      pending_reqs.push_back(make_sample(11585, 11585, 11585, 0, 0, 0));
      pending_reqs.push_back(make_sample(0, -16384, -16384, 0, 0, 0));
      pending_reqs.push_back(make_sample(21845, 0, -21845, 5, 5, 5));
      queue_random(200);
      drain();

      configure(imc_pkg::ALPHA_ONE, 16'hFFFF, 16'hFFFF);
      send_idle_pct = 84;
      queue_random(250);
      drain();

      configure(16'd0, 16'd1, 16'd1);
      send_idle_pct = 0; rsp_idle_pct = 84;
      queue_random(250);
      drain();

      // A gyro weight above one acts as one; zero period and scale stop integration.
      configure(16'd40000, 16'd0, 16'd0);
      send_idle_pct = 7; rsp_idle_pct = 7;
      queue_random(250);
      drain();

      configure(16'd16384, 16'd1000, 16'd8000);
      send_idle_pct = 0; rsp_idle_pct = 0;
      rsp_hold_cycles = 4000;
      queue_random(250);
      drain();

      configure(16'($urandom_range(32768)), 16'($urandom_range(65535, 1)),
                16'($urandom_range(65535, 1)));
      send_idle_pct = 7; rsp_idle_pct = 7;
      queue_random(300);
      drain();

      configure(16'hFFFF, 16'hFFFF, 16'd1);
      send_idle_pct = 84; rsp_idle_pct = 0;
      queue_random(300);
      drain();

      if (fail_count == 0) begin
         $display("imu_complementary_attitude test passed");
      end else begin
         $display("imu_complementary_attitude test failed");
      end
      $finish;
   end

endmodule

/* imu_complementary_attitude.f */
hw/rtl/imc_pkg.sv
hw/rtl/imu_complementary_attitude.sv
bench/imu_complementary_attitude_test.sv
